// ===== hdl/sla_pkg.sv =====
`timescale 1ns / 1ps

package sla_pkg;

    // Default sizes of the sample and gain formats
    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int GAIN_FRAC_BITS_DEF = 14;

    // Level register is unsigned Q1.15
    localparam int LEVEL_W    = 16;
    localparam int LEVEL_FRAC = 15;

    // Sample scale factor carries this many fractional bits
    localparam int SCALE_FRAC = 24;

    // Register reset values
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd16384;

    // Register indexes on the configuration port
    localparam logic [0:0] REG_MASTER_LEVEL = 1'b0;
    localparam logic [0:0] REG_AGC_ENABLE   = 1'b1;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCALE = 5'b00010,
        ST_MULT  = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    // Commands from sequencer to datapath
    typedef struct packed {
        logic load;
        logic scale;
        logic mult;
        logic round;
        logic emit;
    } t_dp_cmd;

    // Status from datapath to sequencer
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hdl/stereo_level_agc.sv =====
`timescale 1ns / 1ps
// A result is shown on the master side after its input passes the sequencer's accept
// state, the scale multiply, the sample multiply, the rounding step and the output load;
// the output load waits while the output stalls. A new input is accepted only after the
// previous item has been loaded into the output register.
// Reset (synchronous, active low): gain 1.0, peak 0, master_level 0.5, AGC off,
// output empty.

module stereo_level_agc
    import sla_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    localparam int IN_DW  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((2 * SAMPLE_WIDTH + GAIN_FRAC_BITS + 3 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // left_in, right_in, zero fill
    input  logic              s_axis_tlast,   // block_last
    input  logic              s_axis_tuser,   // bypass_agc
    // Output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // left_out, right_out, gain_now, zero fill
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int S  = SAMPLE_WIDTH;
    localparam int GW = GAIN_FRAC_BITS + 3;

    logic [LEVEL_W-1:0] r_master_level;
    logic               r_agc_enable;
    logic               cfg_wr;
    t_dp_cmd            dp_cmd;
    t_dp_sts            dp_sts;
    logic [S-1:0]       out_l, out_r;
    logic [GW-1:0]      out_gain;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_level <= LEVEL_RESET;
            r_agc_enable   <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2:2] == REG_MASTER_LEVEL) begin
                r_master_level <= pwdata[LEVEL_W-1:0];
            end
            if (paddr[2:2] == REG_AGC_ENABLE) begin
                r_agc_enable <= pwdata[0];
            end
        end
    end

    // Register read back
    always_comb begin
        if (paddr[2:2] == REG_AGC_ENABLE) begin
            prdata = {31'd0, r_agc_enable};
        end else begin
            prdata = {{(32 - LEVEL_W){1'b0}}, r_master_level};
        end
    end

    sla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (dp_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (dp_cmd)
    );

    sla_dp #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_master_level (r_master_level),
        .i_agc_enable   (r_agc_enable),
        .i_left         (s_axis_tdata[S-1:0]),
        .i_right        (s_axis_tdata[2*S-1:S]),
        .i_last         (s_axis_tlast),
        .i_bypass       (s_axis_tuser),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_left         (out_l),
        .o_right        (out_r),
        .o_gain         (out_gain)
    );

    // Pack result fields, lowest first
    assign m_axis_tdata = OUT_DW'({out_gain, out_r, out_l});

endmodule

// ===== hdl/sla_ctrl.sv =====
`timescale 1ns / 1ps

module sla_ctrl
    import sla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // Step through scale, multiply, round and emit for each item
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: n_state = ST_MULT;
            ST_MULT:  n_state = ST_ROUND;
            ST_ROUND: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive datapath commands from the current state
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cmd.load  = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.scale = (r_state == ST_SCALE);
    assign o_cmd.mult  = (r_state == ST_MULT);
    assign o_cmd.round = (r_state == ST_ROUND);
    assign o_cmd.emit  = (r_state == ST_EMIT) && i_sts.out_free;

endmodule

// ===== hdl/sla_dp.sv =====
`timescale 1ns / 1ps

module sla_dp
    import sla_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    input  logic [LEVEL_W-1:0]          i_master_level,
    input  logic                        i_agc_enable,
    input  logic [SAMPLE_WIDTH-1:0]     i_left,
    input  logic [SAMPLE_WIDTH-1:0]     i_right,
    input  logic                        i_last,
    input  logic                        i_bypass,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [SAMPLE_WIDTH-1:0]     o_left,
    output logic [SAMPLE_WIDTH-1:0]     o_right,
    output logic [GAIN_FRAC_BITS+2:0]   o_gain
);

    localparam int S     = SAMPLE_WIDTH;
    localparam int GW    = GAIN_FRAC_BITS + 3;
    localparam int FW    = GW + LEVEL_W;
    localparam int SHIFT = GAIN_FRAC_BITS + LEVEL_FRAC - SCALE_FRAC;
    localparam int SCW   = FW - SHIFT;
    localparam int PW    = S + SCW;
    localparam int RW    = PW - SCALE_FRAC;

    localparam logic [GW-1:0] GAIN_ONE  = GW'(1) << GAIN_FRAC_BITS;
    localparam logic [GW-1:0] GAIN_MAX  = GW'(1) << (GAIN_FRAC_BITS + 2);
    localparam logic [GW-1:0] GAIN_MIN  = GW'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic [GW-1:0] GAIN_STEP = GW'(((1 << GAIN_FRAC_BITS) + 50) / 100);
    localparam logic [S-1:0]  FULL_SCALE = S'(1) << (S - 4);
    localparam logic [S-1:0]  SMP_HALF   = S'(1) << (S - 1);

    logic [S-1:0]   r_mag_l, r_mag_r;
    logic           r_neg_l, r_neg_r;
    logic           r_last, r_bypass;
    logic [SCW-1:0] r_scale;
    logic [PW-1:0]  r_prod_l, r_prod_r;
    logic [S-1:0]   r_res_l, r_res_r;
    logic [GW-1:0]  r_gain;
    logic [S-1:0]   r_peak;
    logic           r_out_valid;
    logic [S-1:0]   r_out_l, r_out_r;
    logic [GW-1:0]  r_out_gain;

    logic [FW-1:0]  full_w;
    logic [FW-1:0]  full_rnd;
    logic [PW-1:0]  sum_l, sum_r;
    logic [RW-1:0]  res_l, res_r;
    logic [S-1:0]   sat_l, sat_r;
    logic [S-1:0]   lim_l, lim_r;
    logic [S-1:0]   n_peak;
    logic [GW-1:0]  n_gain;
    logic [GW-1:0]  g_step;

    // Scale factor: gain times level, rounded to SCALE_FRAC fraction bits
    assign full_w   = FW'(r_gain) * FW'(i_master_level);
    assign full_rnd = full_w + (FW'(1) << (SHIFT - 1));

    // Round magnitudes half away from zero and saturate
    assign sum_l = r_prod_l + (PW'(1) << (SCALE_FRAC - 1));
    assign sum_r = r_prod_r + (PW'(1) << (SCALE_FRAC - 1));
    assign res_l = sum_l[PW-1:SCALE_FRAC];
    assign res_r = sum_r[PW-1:SCALE_FRAC];
    assign lim_l = r_neg_l ? SMP_HALF : (SMP_HALF - S'(1));
    assign lim_r = r_neg_r ? SMP_HALF : (SMP_HALF - S'(1));
    assign sat_l = (res_l > RW'(lim_l)) ? lim_l : res_l[S-1:0];
    assign sat_r = (res_r > RW'(lim_r)) ? lim_r : res_r[S-1:0];

    // Running peak over the block
    always_comb begin
        n_peak = r_peak;
        if (sat_l > n_peak) begin
            n_peak = sat_l;
        end
        if (sat_r > n_peak) begin
            n_peak = sat_r;
        end
    end

    // Block-end gain step, clamped to 0.5 .. 4.0; gain returns to 1.0 on bypass or AGC off
    always_comb begin
        if (r_peak < FULL_SCALE) begin
            g_step = r_gain + GAIN_STEP;
        end else if (r_gain > GAIN_STEP) begin
            g_step = r_gain - GAIN_STEP;
        end else begin
            g_step = '0;
        end
        if (!r_bypass && i_agc_enable) begin
            if (g_step > GAIN_MAX) begin
                n_gain = GAIN_MAX;
            end else if (g_step < GAIN_MIN) begin
                n_gain = GAIN_MIN;
            end else begin
                n_gain = g_step;
            end
        end else begin
            n_gain = GAIN_ONE;
        end
    end

    // Item payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg_l  <= i_left[S-1];
            r_neg_r  <= i_right[S-1];
            r_mag_l  <= i_left[S-1]  ? (~i_left + S'(1))  : i_left;
            r_mag_r  <= i_right[S-1] ? (~i_right + S'(1)) : i_right;
            r_last   <= i_last;
            r_bypass <= i_bypass;
        end
        if (i_cmd.scale) begin
            r_scale <= full_rnd[FW-1:SHIFT];
        end
        if (i_cmd.mult) begin
            r_prod_l <= PW'(r_mag_l) * PW'(r_scale);
            r_prod_r <= PW'(r_mag_r) * PW'(r_scale);
        end
        if (i_cmd.round) begin
            r_res_l <= sat_l;
            r_res_r <= sat_r;
        end
        if (i_cmd.emit) begin
            r_out_l    <= r_neg_l ? (~r_res_l + S'(1)) : r_res_l;
            r_out_r    <= r_neg_r ? (~r_res_r + S'(1)) : r_res_r;
            r_out_gain <= r_gain;
        end
    end

    // Gain, peak and output valid state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_ONE;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.round) begin
                r_peak <= n_peak;
            end
            if (i_cmd.emit && r_last) begin
                r_gain <= n_gain;
                r_peak <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_left         = r_out_l;
    assign o_right        = r_out_r;
    assign o_gain         = r_out_gain;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sla_pkg::*;

    localparam int SW          = SAMPLE_WIDTH_DEF;
    localparam int GF          = GAIN_FRAC_BITS_DEF;
    localparam int IN_DW       = ((2 * SW + 7) / 8) * 8;
    localparam int OUT_DW      = ((2 * SW + GF + 3 + 7) / 8) * 8;
    localparam int LATENCY     = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTS  = 40;

    // Fixed-point constants of the gain loop
    localparam longint GAIN_ONE    = 64'd1 << GF;
    localparam longint GAIN_STEP   = (GAIN_ONE + 50) / 100;
    localparam longint GAIN_MAX    = GAIN_ONE * 4;
    localparam longint GAIN_MIN    = GAIN_ONE / 2;
    localparam longint FULL_SCALE  = 64'd1 << (SW - 4);
    localparam int     SCALE_SHIFT = GF + LEVEL_FRAC - SCALE_FRAC;

    typedef struct packed {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
        logic          last;
        logic          byp;
    } t_pair_in;

    typedef struct packed {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
        logic [GF+2:0] gain;
    } t_pair_out;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {AMP_QUIET, AMP_LOUD, AMP_MIXED} t_amp;

    typedef struct packed {
        t_row_kind    kind;
        logic [15:0]  cfg_level;
        logic         cfg_en;
        t_pair_in     pair;
        logic         typed;
        t_pair_out    want;
    } t_row;

    typedef struct {
        int   level;      // negative: random word
        int   enable;     // negative: random word
        t_amp amp;
        int   byp_pct;
        int   max_blk;
        int   items;
        int   send_pct;
        int   recv_pct;
    } t_phase;

    localparam t_pair_out NO_WANT = '0;

    // Directed stimulus; expectations typed in only where obvious
    t_row dir_rows [0:16] = '{
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h000000, 24'h000000, 1'b0, 1'b0},
          1'b1, '{24'h000000, 24'h000000, 17'd16384}},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h7FFFFF, 24'h800000, 1'b0, 1'b0},
          1'b1, '{24'h400000, 24'hC00000, 17'd16384}},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h000001, 24'hFFFFFF, 1'b0, 1'b0},
          1'b1, '{24'h000001, 24'hFFFFFF, 17'd16384}},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h000003, 24'hFFFFFD, 1'b0, 1'b0},
          1'b1, '{24'h000002, 24'hFFFFFE, 17'd16384}},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h000002, 24'hFFFFFE, 1'b1, 1'b1},
          1'b1, '{24'h000001, 24'hFFFFFF, 17'd16384}},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h000005, 24'h000007, 1'b0, 1'b1},
          1'b1, '{24'h000003, 24'h000004, 17'd16384}},
        '{ROW_CFG, 16'd32768, 1'b1, '0, 1'b0, NO_WANT},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h0003E8, 24'hFFFC18, 1'b1, 1'b0},
          1'b1, '{24'h0003E8, 24'hFFFC18, 17'd16384}},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h000000, 24'h000000, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h100000, 24'h000000, 1'b1, 1'b0}, 1'b0, NO_WANT},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h001000, 24'h001000, 1'b1, 1'b1}, 1'b0, NO_WANT},
        '{ROW_CFG, 16'd65535, 1'b1, '0, 1'b0, NO_WANT},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h7FFFFF, 24'h800000, 1'b1, 1'b0},
          1'b1, '{24'h7FFFFF, 24'h800000, 17'd16384}},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h800000, 24'h7FFFFF, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{ROW_CFG, 16'd0, 1'b1, '0, 1'b0, NO_WANT},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h7FFFFF, 24'h800000, 1'b1, 1'b0}, 1'b0, NO_WANT},
        '{ROW_ITEM, 16'd0, 1'b0, '{24'h123456, 24'h654321, 1'b1, 1'b0}, 1'b0, NO_WANT}
    };

    // Random phases: climb to the gain ceiling, mixed traffic with AGC off, fall to the floor, then mixed traffic
    t_phase phases [0:5] = '{
        '{32768, 1,  AMP_QUIET, 0,  2, 600, 0,  0},
        '{-1,    0,  AMP_MIXED, 30, 6, 200, 62, 0},
        '{65535, 1,  AMP_LOUD,  0,  2, 300, 0,  62},
        '{-1,    1,  AMP_MIXED, 10, 8, 300, 38, 38},
        '{0,     3,  AMP_MIXED, 10, 4, 150, 0,  0},
        '{-1,    -1, AMP_MIXED, 20, 5, 400, 0,  62}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata;   // left_in, right_in
    logic              s_axis_tlast;   // block_last
    logic              s_axis_tuser;   // bypass_agc
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_DW-1:0] m_axis_tdata;   // left_out, right_out, gain_now, zero fill
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Predictor state and its copy of the registers
    logic [GF+2:0]     tracked_gain;
    logic [SW-1:0]     tracked_peak;
    logic [15:0]       cur_level;
    logic              cur_agc_on;

    t_pair_out         scaled_pairs_q [$];
    int                mismatch_count = 0;
    int                results_seen   = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;

    stereo_level_agc i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Scale one sample magnitude, round half away from zero, saturate
    function automatic logic [SW-1:0] scale_sample(input logic [SW-1:0] smp,
                                                   input longint unsigned factor,
                                                   output logic [SW-1:0] mag);
        logic            neg;
        longint unsigned m;
        longint unsigned res;
        longint unsigned limit;
        neg   = smp[SW-1];
        m     = neg ? ((64'd1 << SW) - 64'(smp)) : 64'(smp);
        res   = (m * factor + (64'd1 << (SCALE_FRAC - 1))) >> SCALE_FRAC;
        limit = neg ? (64'd1 << (SW - 1)) : ((64'd1 << (SW - 1)) - 1);
        if (res > limit)
            res = limit;
        mag = res[SW-1:0];
        return neg ? (SW'(0) - res[SW-1:0]) : res[SW-1:0];
    endfunction

    // Work out one output transaction and advance the gain loop
    function automatic t_pair_out predict_pair(input t_pair_in it);
        t_pair_out       o;
        longint unsigned factor;
        longint unsigned g;
        logic [SW-1:0]   mag_l;
        logic [SW-1:0]   mag_r;
        factor  = (64'(tracked_gain) * 64'(cur_level) + (64'd1 << (SCALE_SHIFT - 1)))
                  >> SCALE_SHIFT;
        o.left  = scale_sample(it.left, factor, mag_l);
        o.right = scale_sample(it.right, factor, mag_r);
        o.gain  = tracked_gain;
        if (mag_l > tracked_peak)
            tracked_peak = mag_l;
        if (mag_r > tracked_peak)
            tracked_peak = mag_r;
        if (it.last) begin
            if (!it.byp && cur_agc_on) begin
                g = 64'(tracked_gain);
                if (64'(tracked_peak) < FULL_SCALE)
                    g = g + GAIN_STEP;
                else
                    g = (g > GAIN_STEP) ? (g - GAIN_STEP) : 0;
                if (g > GAIN_MAX)
                    g = GAIN_MAX;
                else if (g < GAIN_MIN)
                    g = GAIN_MIN;
                tracked_gain = g[GF+2:0];
            end else begin
                tracked_gain = GAIN_ONE[GF+2:0];
            end
            tracked_peak = '0;
        end
        return o;
    endfunction

    function automatic logic [SW-1:0] rand_sample(input t_amp amp);
        int pick;
        pick = $urandom_range(9);
        if (amp == AMP_QUIET || (amp == AMP_MIXED && pick >= 1 && pick <= 4))
            return SW'(int'($urandom_range(0, 262143)) - 131072);
        if (amp == AMP_MIXED && pick == 0) begin
            case ($urandom_range(4))
                0:       return '0;
                1:       return SW'(1);
                2:       return '1;
                3:       return {1'b0, {(SW-1){1'b1}}};
                default: return {1'b1, {(SW-1){1'b0}}};
            endcase
        end
        return SW'($urandom());
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("result %0d %s: got %h, expected %h", results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Present one pair, hold until accepted, record its expected output
    task automatic send_pair(input t_pair_in it, input logic typed, input t_pair_out want);
        t_pair_out guess;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DW'({it.right, it.left});
        s_axis_tlast  <= it.last;
        s_axis_tuser  <= it.byp;
        do @(posedge i_clk); while (!s_axis_tready);
        guess = predict_pair(it);
        if (typed)
            guess = want;
        scaled_pairs_q = {scaled_pairs_q, guess};
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every pending output, then let the pipeline drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (scaled_pairs_q.size() != 0)
            @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    // Register write followed by a readback
    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_MASTER_LEVEL)
            cur_level = value[15:0];
        else
            cur_agc_on = value[0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (idx == REG_MASTER_LEVEL && got[15:0] !== value[15:0])
            flag_mismatch("master_level readback", got, value & 32'hFFFF);
        if (idx == REG_AGC_ENABLE && got[0] !== value[0])
            flag_mismatch("agc_enable readback", got, value & 32'h1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Randomly stall the output side
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare every output transaction with the oldest expected pair
    always @(posedge i_clk) begin : check_outputs
        t_pair_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (scaled_pairs_q.size() == 0) begin
                flag_mismatch("unexpected result", m_axis_tdata[31:0], '0);
            end else begin
                want = scaled_pairs_q.pop_front();
                if (m_axis_tdata[SW-1:0] !== want.left)
                    flag_mismatch("left_out", 32'(m_axis_tdata[SW-1:0]), 32'(want.left));
                if (m_axis_tdata[2*SW-1:SW] !== want.right)
                    flag_mismatch("right_out", 32'(m_axis_tdata[2*SW-1:SW]),
                                  32'(want.right));
                if (m_axis_tdata[2*SW+GF+2:2*SW] !== want.gain)
                    flag_mismatch("gain_now", 32'(m_axis_tdata[2*SW+GF+2:2*SW]),
                                  32'(want.gain));
            end
            results_seen++;
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        t_pair_in    pair;
        logic [31:0] level_word;
        logic [31:0] enable_word;
        int          blk_left;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tracked_gain  = GAIN_ONE[GF+2:0];
        tracked_peak  = '0;
        cur_level     = LEVEL_RESET;
        cur_agc_on    = 1'b0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                settle();
                write_reg(REG_MASTER_LEVEL, 32'(dir_rows[k].cfg_level));
                write_reg(REG_AGC_ENABLE, 32'(dir_rows[k].cfg_en));
            end else begin
                send_pair(dir_rows[k].pair, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        // Random phases with render blocks of random length
        foreach (phases[p]) begin
            settle();
            level_word  = (phases[p].level < 0) ? $urandom()
                        : {16'($urandom()), 16'(phases[p].level)};
            enable_word = (phases[p].enable < 0) ? $urandom() : 32'(phases[p].enable);
            write_reg(REG_MASTER_LEVEL, level_word);
            write_reg(REG_AGC_ENABLE, enable_word);
            send_idle_pct  = phases[p].send_pct;
            recv_stall_pct = phases[p].recv_pct;
            blk_left       = 0;
            repeat (phases[p].items) begin
                if (blk_left == 0)
                    blk_left = $urandom_range(1, phases[p].max_blk);
                pair.left  = rand_sample(phases[p].amp);
                pair.right = rand_sample(phases[p].amp);
                pair.last  = (blk_left == 1);
                pair.byp   = ($urandom_range(99) < phases[p].byp_pct);
                blk_left--;
                send_pair(pair, 1'b0, NO_WANT);
            end
        end

        settle();
        repeat (LATENCY * 4) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
